@@ sv/median_3x3_filter_defines.svh @@
// Assertion macros for the median filter.
// Define ASSERT_OFF to compile the checks away.
`ifndef MEDIAN_3X3_FILTER_DEFINES_SVH
`define MEDIAN_3X3_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset
`define MF3_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("median filter check failed");
// Check a property on every rising clock edge, no reset qualifier
`define MF3_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("median filter check failed");
`else
`define MF3_ASSERT(lbl, clk, rst, prop)
`define MF3_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ sv/mf3_pkg.sv @@
`timescale 1ns / 1ps
package mf3_pkg;

   // Channels per pixel (red, green, blue, alpha from LSB up)
   localparam int NUM_CH = 4;

   // Size registers
   localparam int CFG_W     = 12;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_IDX  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_IDX = CSR_IDX_W'(1);
   localparam logic [CFG_W-1:0]     CFG_RESET      = CFG_W'(2048);

   // Coordinates and row counting
   localparam int COORD_W   = 11;
   localparam int ROW_W     = 11;
   localparam int ROW_LIMIT = 2048;

   // Coordinates and end marker that travel with each result
   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               last_of_run;
   } tag_type;

endpackage

@@ sv/mf3_line_store.sv @@
`timescale 1ns / 1ps
`include "median_3x3_filter_defines.svh"
module mf3_line_store #(
   parameter int DEPTH  = 2048,
   parameter int DATA_W = 64
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] q_ff;
   logic [DATA_W-1:0] byp_data_ff;
   logic              byp_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; hold the last read, forward a write to the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff        <= mem[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : q_ff;

   `MF3_ASSERT_NR(a_same_entry_bypass, clock,
      rd_en && wr_en && (rd_addr == wr_addr) |=> rd_data == $past(wr_data))

endmodule

@@ sv/mf3_median_pipe.sv @@
`timescale 1ns / 1ps
`include "median_3x3_filter_defines.svh"
module mf3_median_pipe
   import mf3_pkg::*;
#(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   output logic                                         in_ready,
   input  logic [2:0][2:0][NUM_CH*CHANNEL_BITS-1:0]     in_window,
   input  tag_type                                      in_tag,
   output logic                                         out_valid,
   input  logic                                         out_ready,
   output logic [NUM_CH-1:0][CHANNEL_BITS-1:0]          out_median,
   output tag_type                                      out_tag
);

   localparam int PIX_W = NUM_CH * CHANNEL_BITS;

   typedef logic [CHANNEL_BITS-1:0] chan_type;

   function automatic chan_type min2(input chan_type a, input chan_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic chan_type max2(input chan_type a, input chan_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic chan_type med3(input chan_type a, input chan_type b, input chan_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   // Sorted triple: index 0 low, 1 middle, 2 high
   function automatic logic [2:0][CHANNEL_BITS-1:0] sort3(input chan_type a, input chan_type b,
                                                          input chan_type c);
      chan_type                      l1;
      chan_type                      h1;
      chan_type                      m1;
      logic [2:0][CHANNEL_BITS-1:0]  s;
      l1   = min2(a, b);
      h1   = max2(a, b);
      m1   = min2(h1, c);
      s[2] = max2(h1, c);
      s[0] = min2(l1, m1);
      s[1] = max2(l1, m1);
      return s;
   endfunction

   // Stage registers
   logic                                        st0_v_ff;
   logic [2:0][2:0][PIX_W-1:0]                  st0_win_ff;
   tag_type                                     st0_tag_ff;
   logic                                        st1_v_ff;
   logic [NUM_CH-1:0][2:0][2:0][CHANNEL_BITS-1:0] st1_sort_ff;
   logic [NUM_CH-1:0][2:0][2:0][CHANNEL_BITS-1:0] st1_sort_in;
   tag_type                                     st1_tag_ff;
   logic                                        st2_v_ff;
   logic [NUM_CH-1:0][2:0][CHANNEL_BITS-1:0]    st2_part_ff;
   logic [NUM_CH-1:0][2:0][CHANNEL_BITS-1:0]    st2_part_in;
   tag_type                                     st2_tag_ff;
   logic                                        out_v_ff;
   logic [NUM_CH-1:0][CHANNEL_BITS-1:0]         out_med_ff;
   logic [NUM_CH-1:0][CHANNEL_BITS-1:0]         out_med_in;
   tag_type                                     out_tag_ff;

   logic out_free;
   logic st2_free;
   logic st1_free;
   logic st0_free;

   // A stage may load when it is empty or its content moves on
   assign out_free = !out_v_ff || out_ready;
   assign st2_free = !st2_v_ff || out_free;
   assign st1_free = !st1_v_ff || st2_free;
   assign st0_free = !st0_v_ff || st1_free;
   assign in_ready = st0_free;

   // Sort each column of each channel
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int col = 0; col < 3; col++) begin
            st1_sort_in[ch][col] = sort3(st0_win_ff[col][0][ch*CHANNEL_BITS +: CHANNEL_BITS],
                                         st0_win_ff[col][1][ch*CHANNEL_BITS +: CHANNEL_BITS],
                                         st0_win_ff[col][2][ch*CHANNEL_BITS +: CHANNEL_BITS]);
         end
      end
   end

   // Max of lows, median of middles, min of highs
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         st2_part_in[ch][0] = max2(max2(st1_sort_ff[ch][0][0], st1_sort_ff[ch][1][0]),
                                   st1_sort_ff[ch][2][0]);
         st2_part_in[ch][1] = med3(st1_sort_ff[ch][0][1], st1_sort_ff[ch][1][1],
                                   st1_sort_ff[ch][2][1]);
         st2_part_in[ch][2] = min2(min2(st1_sort_ff[ch][0][2], st1_sort_ff[ch][1][2]),
                                   st1_sort_ff[ch][2][2]);
      end
   end

   // Median of the three partial results
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         out_med_in[ch] = med3(st2_part_ff[ch][0], st2_part_ff[ch][1], st2_part_ff[ch][2]);
      end
   end

   // Advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         st0_v_ff <= 1'b0;
         st1_v_ff <= 1'b0;
         st2_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (st0_free) begin
            st0_v_ff <= in_valid;
         end
         if (st1_free) begin
            st1_v_ff <= st0_v_ff;
         end
         if (st2_free) begin
            st2_v_ff <= st1_v_ff;
         end
         if (out_free) begin
            out_v_ff <= st2_v_ff;
         end
      end
   end

   // Advance stage payloads
   always_ff @(posedge clock) begin
      if (st0_free) begin
         st0_win_ff <= in_window;
         st0_tag_ff <= in_tag;
      end
      if (st1_free) begin
         st1_sort_ff <= st1_sort_in;
         st1_tag_ff  <= st0_tag_ff;
      end
      if (st2_free) begin
         st2_part_ff <= st2_part_in;
         st2_tag_ff  <= st1_tag_ff;
      end
      if (out_free) begin
         out_med_ff <= out_med_in;
         out_tag_ff <= st2_tag_ff;
      end
   end

   assign out_valid  = out_v_ff;
   assign out_median = out_med_ff;
   assign out_tag    = out_tag_ff;

   `MF3_ASSERT(a_accept_fills_stage, clock, reset, in_valid && in_ready |=> st0_v_ff)
   `MF3_ASSERT(a_stalled_stage_holds, clock, reset,
      st2_v_ff && !out_free |=> st2_v_ff && $stable(st2_tag_ff))
   `MF3_ASSERT(a_result_follows_stage, clock, reset,
      st2_v_ff && out_free |=> out_valid && (out_tag == $past(st2_tag_ff)))

endmodule

@@ sv/median_3x3_filter.sv @@
`timescale 1ns / 1ps
`include "median_3x3_filter_defines.svh"
// Streaming channel-wise 3x3 median filter, clamp-to-edge borders.
// Input channel req_*: one pixel per transaction, raster order, four channels.
// Result channel rsp_*: per-channel medians tagged with output column and row;
// rsp_last_of_run marks the final result caused by one input pixel.
// Configuration port csr_*: index 0 is the row width, index 1 the frame height;
// a write to either restarts the frame at column 0, row 0. Write only while idle.
// Results trail the input by one row and one column. An input on the first row
// of a frame taller than one row gives no result, a row end gives two, and the
// last row doubles that, so one input gives zero to four results.
// Throughput: one pixel per cycle. An input that gives n results holds the emit
// stage while it issues them one at a time, so the rate drops only at row ends,
// on the last row and with rsp_ready low. Each line store entry is read once and
// written once per pixel through one read and one write port of a single memory.
// A pixel's first result passes the read, emit and median stages before rsp_*.
// Reset: counters to zero, sizes to 2048, pipeline empty; the line store is not
// cleared, entries are written before any result depends on them.
// Stall: a result holds on rsp_* while rsp_ready is low; at most six pixels that
// cause results are still taken before req_ready falls (four median stages, the
// emit stage and the read stage); pixels that cause no result keep flowing.
module median_3x3_filter
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH    = 2048,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]         csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CHANNEL_BITS-1:0]  req_pixel_red,
   input  logic [CHANNEL_BITS-1:0]  req_pixel_green,
   input  logic [CHANNEL_BITS-1:0]  req_pixel_blue,
   input  logic [CHANNEL_BITS-1:0]  req_pixel_alpha,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CHANNEL_BITS-1:0]  rsp_median_red,
   output logic [CHANNEL_BITS-1:0]  rsp_median_green,
   output logic [CHANNEL_BITS-1:0]  rsp_median_blue,
   output logic [CHANNEL_BITS-1:0]  rsp_median_alpha,
   output logic [COORD_W-1:0]       rsp_out_column,
   output logic [COORD_W-1:0]       rsp_out_row,
   output logic                     rsp_last_of_run
);

   localparam int PIX_W     = NUM_CH * CHANNEL_BITS;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int CMP_W     = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
   localparam int NUM_KINDS = 4;
   // Result kinds in emit order
   localparam int KIND_UP_MAIN = 0;
   localparam int KIND_UP_EDGE = 1;
   localparam int KIND_LO_MAIN = 2;
   localparam int KIND_LO_EDGE = 3;

   // Rows of one column: 0 two above, 1 above, 2 incoming
   typedef logic [2:0][PIX_W-1:0] column_type;

   typedef struct packed {
      logic row_is_one;
      logic row_is_zero;
      logic col_ge_one;
      logic col_ge_two;
   } pos_flags_type;

   function automatic column_type rowsel(input column_type col, input logic lower,
                                         input pos_flags_type f);
      column_type s;
      if (lower) begin
         s[0] = f.row_is_zero ? col[2] : col[1];
         s[1] = col[2];
         s[2] = col[2];
      end else begin
         s[0] = f.row_is_one ? col[1] : col[0];
         s[1] = col[1];
         s[2] = col[2];
      end
      return s;
   endfunction

   // Size registers and frame position
   logic [CFG_W-1:0]   width_ff;
   logic [CFG_W-1:0]   height_ff;
   logic [COL_W-1:0]   col_cnt_ff;
   logic [COL_W-1:0]   col_cnt_in;
   logic [ROW_W-1:0]   row_cnt_ff;
   logic [ROW_W-1:0]   row_cnt_in;
   logic [CMP_W-1:0]   w_eff;
   logic [CFG_W-1:0]   h_eff;
   logic [COL_W-1:0]   w_last;
   logic [ROW_W-1:0]   h_last;
   logic               csr_hit;
   logic               accept;

   // Read stage
   logic                 s1_v_ff;
   logic [PIX_W-1:0]     s1_px_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic [ROW_W-1:0]     s1_row_ff;
   logic [NUM_KINDS-1:0] s1_pend_ff;
   logic [NUM_KINDS-1:0] s1_pend_in;
   pos_flags_type        s1_flags_ff;
   pos_flags_type        s1_flags_in;
   logic [2*PIX_W-1:0]   rd_data;
   column_type           s1_column;
   logic                 s1_adv;

   // Window and emit stage
   column_type           win_a_ff;
   column_type           win_b_ff;
   logic                 s2_v_ff;
   logic [NUM_KINDS-1:0] s2_pend_ff;
   column_type           s2_a_ff;
   column_type           s2_b_ff;
   column_type           s2_c_ff;
   logic [COL_W-1:0]     s2_col_ff;
   logic [ROW_W-1:0]     s2_row_ff;
   pos_flags_type        s2_flags_ff;
   logic [NUM_KINDS-1:0] s2_pick;
   logic [NUM_KINDS-1:0] s2_left;
   logic                 s2_last;
   logic                 s2_issue;
   logic                 s2_free;
   logic                 s2_load;
   logic                 is_main;
   logic                 is_lower;
   column_type           left_col;
   column_type           center_col;
   logic [COL_W-1:0]     out_x;

   // Median pipeline link
   logic                                 m_ready;
   column_type [2:0]                     m_window;
   tag_type                              m_tag;
   logic [NUM_CH-1:0][CHANNEL_BITS-1:0]  m_median;
   tag_type                              m_out_tag;

   // Clamp sizes: zero acts as one, oversize acts as the limit
   always_comb begin
      w_eff = CMP_W'(width_ff);
      if (w_eff == '0) begin
         w_eff = CMP_W'(1);
      end
      if (w_eff > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end
      w_last = COL_W'(w_eff - CMP_W'(1));
      h_eff  = height_ff;
      if (h_eff == '0) begin
         h_eff = CFG_W'(1);
      end
      if (h_eff > CFG_W'(ROW_LIMIT)) begin
         h_eff = CFG_W'(ROW_LIMIT);
      end
      h_last = ROW_W'(h_eff - CFG_W'(1));
   end

   assign csr_hit = csr_write_en &&
                    ((csr_index == CSR_WIDTH_IDX) || (csr_index == CSR_HEIGHT_IDX));
   assign accept  = req_valid && req_ready;

   // Take size writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_RESET;
         height_ff <= CFG_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WIDTH_IDX: begin
               width_ff <= csr_wdata;
            end
            CSR_HEIGHT_IDX: begin
               height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Advance column and row, restart the frame on a size write
   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (csr_hit) begin
         col_cnt_in = '0;
         row_cnt_in = '0;
      end else if (accept) begin
         if (col_cnt_ff == w_last) begin
            col_cnt_in = '0;
            row_cnt_in = (row_cnt_ff == h_last) ? '0 : row_cnt_ff + ROW_W'(1);
         end else begin
            col_cnt_in = col_cnt_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // Decide which results the incoming pixel causes
   always_comb begin
      s1_flags_in.row_is_one  = (row_cnt_ff == ROW_W'(1));
      s1_flags_in.row_is_zero = (row_cnt_ff == '0);
      s1_flags_in.col_ge_one  = (col_cnt_ff != '0);
      s1_flags_in.col_ge_two  = (col_cnt_ff >= COL_W'(2));
      s1_pend_in[KIND_UP_MAIN] = !s1_flags_in.row_is_zero && s1_flags_in.col_ge_one;
      s1_pend_in[KIND_UP_EDGE] = !s1_flags_in.row_is_zero && (col_cnt_ff == w_last);
      s1_pend_in[KIND_LO_MAIN] = (row_cnt_ff == h_last) && s1_flags_in.col_ge_one;
      s1_pend_in[KIND_LO_EDGE] = (row_cnt_ff == h_last) && (col_cnt_ff == w_last);
   end

   // Read stage: one transaction waits here for its line store data
   assign s1_adv    = s1_v_ff && ((s1_pend_ff == '0) || s2_free);
   assign req_ready = !s1_v_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (req_ready) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff    <= {req_pixel_alpha, req_pixel_blue, req_pixel_green, req_pixel_red};
         s1_col_ff   <= col_cnt_ff;
         s1_row_ff   <= row_cnt_ff;
         s1_pend_ff  <= s1_pend_in;
         s1_flags_ff <= s1_flags_in;
      end
   end

   // Line store entry: upper half two rows above, lower half one row above
   mf3_line_store #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (2 * PIX_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_cnt_ff),
      .rd_data (rd_data),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data ({rd_data[PIX_W-1:0], s1_px_ff})
   );

   assign s1_column[0] = rd_data[2*PIX_W-1:PIX_W];
   assign s1_column[1] = rd_data[PIX_W-1:0];
   assign s1_column[2] = s1_px_ff;

   // Emit stage: lowest pending kind first, one result per cycle while m_ready
   assign s2_pick  = s2_pend_ff & (~s2_pend_ff + NUM_KINDS'(1));
   assign s2_left  = s2_pend_ff & ~s2_pick;
   assign s2_last  = (s2_left == '0);
   assign s2_issue = s2_v_ff && m_ready;
   assign s2_free  = !s2_v_ff || (s2_issue && s2_last);
   assign s2_load  = s1_adv && (s1_pend_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff    <= 1'b0;
         s2_pend_ff <= '0;
      end else if (s2_load) begin
         s2_v_ff    <= 1'b1;
         s2_pend_ff <= s1_pend_ff;
      end else if (s2_issue) begin
         s2_v_ff    <= !s2_last;
         s2_pend_ff <= s2_left;
      end
   end

   // Shift the window and latch the emit stage columns
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_a_ff <= win_b_ff;
         win_b_ff <= s1_column;
      end
      if (s2_load) begin
         s2_a_ff     <= win_a_ff;
         s2_b_ff     <= win_b_ff;
         s2_c_ff     <= s1_column;
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= s1_row_ff;
         s2_flags_ff <= s1_flags_ff;
      end
   end

   // Select the neighbourhood of the chosen result
   always_comb begin
      is_main  = s2_pick[KIND_UP_MAIN] | s2_pick[KIND_LO_MAIN];
      is_lower = s2_pick[KIND_LO_MAIN] | s2_pick[KIND_LO_EDGE];
      if (is_main) begin
         left_col   = s2_flags_ff.col_ge_two ? s2_a_ff : s2_b_ff;
         center_col = s2_b_ff;
         out_x      = s2_col_ff - COL_W'(1);
      end else begin
         left_col   = s2_flags_ff.col_ge_one ? s2_b_ff : s2_c_ff;
         center_col = s2_c_ff;
         out_x      = s2_col_ff;
      end
      m_window[0]       = rowsel(left_col, is_lower, s2_flags_ff);
      m_window[1]       = rowsel(center_col, is_lower, s2_flags_ff);
      m_window[2]       = rowsel(s2_c_ff, is_lower, s2_flags_ff);
      m_tag.column      = COORD_W'(out_x);
      m_tag.row         = is_lower ? s2_row_ff : s2_row_ff - ROW_W'(1);
      m_tag.last_of_run = s2_last;
   end

   mf3_median_pipe #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_median_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s2_v_ff),
      .in_ready   (m_ready),
      .in_window  (m_window),
      .in_tag     (m_tag),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_median (m_median),
      .out_tag    (m_out_tag)
   );

   assign rsp_median_red   = m_median[0];
   assign rsp_median_green = m_median[1];
   assign rsp_median_blue  = m_median[2];
   assign rsp_median_alpha = m_median[3];
   assign rsp_out_column   = m_out_tag.column;
   assign rsp_out_row      = m_out_tag.row;
   assign rsp_last_of_run  = m_out_tag.last_of_run;

   `MF3_ASSERT(a_emit_has_work, clock, reset, s2_v_ff |-> (s2_pend_ff != '0))
   `MF3_ASSERT(a_position_in_frame, clock, reset,
      (col_cnt_ff <= w_last) && (row_cnt_ff <= h_last))

endmodule
